// ----- hw/rtl/sbls_pkg.sv -----
`default_nettype none

package sbls_pkg;

    localparam int NUM_BANDS = 16;
    localparam int BAND_W    = 4;
    localparam int BIN_W     = 24;
    localparam int SUM_W     = 32;
    localparam int GAIN_W    = 24;
    localparam int LEVEL_W   = 17;
    localparam int COUNT_W   = 9;

    localparam logic [COUNT_W-1:0] BIN_LIMIT   = 9'd255;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 24'd1638;
    localparam logic [LEVEL_W-1:0] ONE_Q16     = 17'd65536;
    localparam logic [BAND_W-1:0]  LAST_BAND   = 4'd15;
    // floor(x / 3) = (x * DIV3_RECIP) >> DIV3_SHIFT, exact for x below 2^19
    localparam logic [17:0]        DIV3_RECIP  = 18'd174763;
    localparam int                 DIV3_SHIFT  = 19;

    typedef struct packed {
        logic signed [BIN_W-1:0] bin_value;
        logic                    last_of_frame;
    } in_item_t;

    typedef struct packed {
        logic [BAND_W-1:0]  band_number;
        logic [LEVEL_W-1:0] band_level;
        logic               last_band;
    } out_item_t;

    // one finished band handed from the binning front to the level unit
    typedef struct packed {
        logic [BAND_W-1:0] band;
        logic [SUM_W-1:0]  sum;
    } band_job_t;

    // last bin of each band (upper band edge minus one)
    function automatic logic [7:0] band_last_bin(input logic [BAND_W-1:0] band);
        logic [7:0] last_bin;
        unique case (band)
            4'd0:    last_bin = 8'd0;
            4'd1:    last_bin = 8'd1;
            4'd2:    last_bin = 8'd2;
            4'd3:    last_bin = 8'd4;
            4'd4:    last_bin = 8'd6;
            4'd5:    last_bin = 8'd9;
            4'd6:    last_bin = 8'd13;
            4'd7:    last_bin = 8'd19;
            4'd8:    last_bin = 8'd27;
            4'd9:    last_bin = 8'd39;
            4'd10:   last_bin = 8'd53;
            4'd11:   last_bin = 8'd73;
            4'd12:   last_bin = 8'd100;
            4'd13:   last_bin = 8'd136;
            4'd14:   last_bin = 8'd186;
            default: last_bin = 8'd254;
        endcase
        return last_bin;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sbls_front.sv -----
`default_nettype none

module sbls_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire sbls_pkg::in_item_t  s_data,
    output logic                     job_valid,
    input  wire logic                job_ready,
    output sbls_pkg::band_job_t      job_data
);

    logic [sbls_pkg::COUNT_W-1:0] bin_count_reg, bin_count_next;
    logic [sbls_pkg::BAND_W:0]    band_reg, band_next;
    logic [sbls_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [sbls_pkg::SUM_W-1:0]   sum_add;
    logic                         in_fire;
    logic                         active;
    logic                         band_done;

    // hold the input whenever the queue cannot take a finished band
    assign s_ready = job_ready;
    assign in_fire = s_valid && s_ready;

    assign active    = (bin_count_reg < sbls_pkg::BIN_LIMIT) && !band_reg[sbls_pkg::BAND_W];
    assign sum_add   = sum_reg + {{(sbls_pkg::SUM_W-sbls_pkg::BIN_W){s_data.bin_value[sbls_pkg::BIN_W-1]}},
                                  s_data.bin_value};
    assign band_done = active && (bin_count_reg[7:0] ==
                       sbls_pkg::band_last_bin(band_reg[sbls_pkg::BAND_W-1:0]));

    assign job_valid     = in_fire && band_done;
    assign job_data.band = band_reg[sbls_pkg::BAND_W-1:0];
    assign job_data.sum  = sum_add;

    always_comb begin
        bin_count_next = bin_count_reg;
        band_next      = band_reg;
        sum_next       = sum_reg;
        if (in_fire) begin
            if (band_done) begin
                sum_next  = '0;
                band_next = band_reg + 1'b1;
            end else if (active) begin
                sum_next = sum_add;
            end
            if (bin_count_reg < sbls_pkg::BIN_LIMIT) begin
                bin_count_next = bin_count_reg + 1'b1;
            end
            if (s_data.last_of_frame) begin
                bin_count_next = '0;
                band_next      = '0;
                sum_next       = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_count_reg <= '0;
            band_reg      <= '0;
            sum_reg       <= '0;
        end else begin
            bin_count_reg <= bin_count_next;
            band_reg      <= band_next;
            sum_reg       <= sum_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        bin_count_reg <= sbls_pkg::BIN_LIMIT)
        else $error("bin count past limit");

    a_band_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        band_reg[sbls_pkg::BAND_W] |-> (band_reg[sbls_pkg::BAND_W-1:0] == '0) &&
                                      (bin_count_reg == sbls_pkg::BIN_LIMIT))
        else $error("all bands done before bin limit");

    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && s_data.last_of_frame |=> (bin_count_reg == '0) && (band_reg == '0) &&
                                           (sum_reg == '0))
        else $error("frame end did not restart binning");

endmodule

`default_nettype wire

// ----- hw/rtl/sbls_queue.sv -----
`default_nettype none

module sbls_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push_valid,
    output logic                      push_ready,
    input  wire sbls_pkg::band_job_t  push_data,
    output logic                      pop_valid,
    input  wire logic                 pop_ready,
    output sbls_pkg::band_job_t       pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    sbls_pkg::band_job_t      slot_reg [DEPTH];
    logic [PTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     push_fire;
    logic                     pop_fire;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire) begin
            count_next = count_reg + 1'b1;
        end else if (pop_fire && !push_fire) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_fire) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("queue count overflow");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) || (count_reg == FULL_CNT) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers out of step with count");

    a_push_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_fire && !push_fire |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop did not reduce count");

endmodule

`default_nettype wire

// ----- hw/rtl/sbls_back.sv -----
`default_nettype none

module sbls_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [sbls_pkg::GAIN_W-1:0] gain,
    input  wire logic                        job_valid,
    output logic                             job_ready,
    input  wire sbls_pkg::band_job_t         job_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output sbls_pkg::out_item_t              m_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_VAL  = 3'd3;
    localparam logic [2:0] ST_NUM  = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    localparam int LW = sbls_pkg::LEVEL_W;

    logic [2:0]                  state_reg, state_next;
    logic [sbls_pkg::BAND_W-1:0] band_reg;
    logic [31:0]                 mag_reg;
    logic [62:0]                 sq_reg;
    logic [43:0]                 p_lo_reg;
    logic [43:0]                 p_hi_reg;
    logic                        big_reg;
    logic [LW-1:0]               value_reg;
    logic [19:0]                 num_reg;
    logic [35:0]                 quo_reg;
    logic [LW-1:0]               level_reg [sbls_pkg::NUM_BANDS];
    logic                        m_valid_reg;
    sbls_pkg::out_item_t         m_data_reg;

    logic [63:0]                 sq_full;
    logic [63:0]                 prod;
    logic [LW-1:0]               value_calc;
    logic [LW-1:0]               level_old;
    logic [19:0]                 num_calc;
    logic [LW-1:0]               level_new;
    logic                        out_free;

    assign job_ready = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;

    assign sq_full    = mag_reg * mag_reg;
    assign prod       = {p_hi_reg, 20'b0} + {20'b0, p_lo_reg};
    // clamp to 1.0 once the Q40 product reaches one
    assign value_calc = (big_reg || (prod[63:40] != '0)) ? sbls_pkg::ONE_Q16
                                                         : {1'b0, prod[39:24]};
    assign level_old  = level_reg[band_reg];
    assign num_calc   = {level_old, 3'b0} + {3'b0, level_old} + {1'b0, value_reg, 2'b0};
    assign level_new  = quo_reg[sbls_pkg::DIV3_SHIFT +: LW];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (job_valid) state_next = ST_SQ;
            ST_SQ:   state_next = ST_MUL;
            ST_MUL:  state_next = ST_VAL;
            ST_VAL:  state_next = ST_NUM;
            ST_NUM:  state_next = ST_DIV;
            ST_DIV:  state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath registers, one step of the level update per state
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && job_valid) begin
            band_reg <= job_data.band;
            mag_reg  <= job_data.sum[31] ? (~job_data.sum + 1'b1) : job_data.sum;
        end
        if (state_reg == ST_SQ) begin
            sq_reg <= sq_full[62:0];
        end
        if (state_reg == ST_MUL) begin
            p_lo_reg <= sq_reg[19:0] * gain;
            p_hi_reg <= sq_reg[39:20] * gain;
            big_reg  <= (sq_reg[62:40] != '0) && (gain != '0);
        end
        if (state_reg == ST_VAL) begin
            value_reg <= value_calc;
        end
        if (state_reg == ST_NUM) begin
            num_reg <= num_calc;
        end
        if (state_reg == ST_DIV) begin
            quo_reg <= num_reg[19:2] * sbls_pkg::DIV3_RECIP;
        end
        if (state_reg == ST_OUT && out_free) begin
            m_data_reg.band_number <= band_reg;
            m_data_reg.band_level  <= level_new;
            m_data_reg.last_band   <= (band_reg == sbls_pkg::LAST_BAND);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < sbls_pkg::NUM_BANDS; i++) begin
                level_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg         <= 1'b1;
                level_reg[band_reg] <= level_new;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.band_level <= 17'd87381)
        else $error("band level above fixed point of smoother");

    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.last_band == (m_data.band_number == sbls_pkg::LAST_BAND))
        else $error("last band flag disagrees with band number");

    a_value_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_NUM |-> value_reg <= sbls_pkg::ONE_Q16)
        else $error("band value not clamped");

endmodule

`default_nettype wire

// ----- hw/rtl/spectrum_band_level_smoother.sv -----
`default_nettype none

// Spectrum band level smoother. Takes one real spectrum bin per transfer, in
// bin order, and sums the bins into 16 fixed bands (edges 0,1,2,3,5,7,10,14,
// 20,28,40,54,74,101,137,187,255); bins from 255 on are dropped. When a
// band's last bin arrives, the band sum is squared, scaled by the gain
// (unsigned Q8.16), clamped to 1.0 and folded into the band's level as
// (9*level + 4*value)/12, and one result transfer carries the new level
// (unsigned Q16). last_of_frame restarts the bin count; a band left unfinished
// at frame end keeps its old level. The binning front takes one bin every
// cycle while the band queue (QUEUE_DEPTH entries) has room. Each band result
// then passes through the level unit, one band at a time, in these steps:
// absolute value, square, gain product in two partial products, sum and
// clamp, level blend, division by three through a reciprocal multiply, and
// write-back into the output register. Bands 0 to 2 end on consecutive
// bins, so a stream at full rate can see s_ready fall near the start of
// each frame. Write the gain only while no band is in flight.

module spectrum_band_level_smoother #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [sbls_pkg::GAIN_W-1:0] cfg_wr_data,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire sbls_pkg::in_item_t          s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output sbls_pkg::out_item_t              m_data
);

    logic [sbls_pkg::GAIN_W-1:0] gain_reg;
    logic                        push_valid;
    logic                        push_ready;
    sbls_pkg::band_job_t         push_data;
    logic                        pop_valid;
    logic                        pop_ready;
    sbls_pkg::band_job_t         pop_data;

    // gain register, written straight from the configuration port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= sbls_pkg::GAIN_RESET;
        end else if (cfg_wr_en) begin
            gain_reg <= cfg_wr_data;
        end
    end

    // binning front: count bins, accumulate, hand off each finished band
    sbls_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_valid (push_valid),
        .job_ready (push_ready),
        .job_data  (push_data)
    );

    // queue of finished bands, decoupling the front from the level unit
    sbls_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // level unit: square, scale, clamp, smooth and present the result
    sbls_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .gain      (gain_reg),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire
